// File: design/rcem_pkg.sv
// Shared constants, types and arithmetic helpers for the Roberts cross edge magnitude unit.
package rcem_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;

	localparam int PIX_W  = 8;
	localparam int COL_W  = 10;
	localparam int ROW_W  = 12;
	localparam int WCFG_W = 11;
	localparam int HCFG_W = 13;
	localparam int CFG_DATA_W = 13;
	localparam int CFG_IDX_W  = 2;

	localparam int NSLOT  = 4;
	localparam int SLOT_W = 2;

	localparam int M_TDATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	// Result slots of one pixel, in delivery order.
	localparam logic [SLOT_W-1:0] SLOT_ABOVE      = 2'd0;
	localparam logic [SLOT_W-1:0] SLOT_ABOVE_EDGE = 2'd1;
	localparam logic [SLOT_W-1:0] SLOT_BOTTOM     = 2'd2;
	localparam logic [SLOT_W-1:0] SLOT_CORNER     = 2'd3;

	localparam logic [PIX_W-1:0] MAG_SAT = 8'd255;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last_col;
		logic             last_row;
	} pos_t;

	typedef struct packed {
		logic [PIX_W-1:0] mag;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} res_t;

	function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [PIX_W-1:0] roberts(input logic [PIX_W-1:0] tl,
		input logic [PIX_W-1:0] tr, input logic [PIX_W-1:0] bl,
		input logic [PIX_W-1:0] br);
		logic [PIX_W:0] sum;
		sum = {1'b0, absdiff(tl, br)} + {1'b0, absdiff(tr, bl)};
		return sum[PIX_W] ? MAG_SAT : sum[PIX_W-1:0];
	endfunction

endpackage

// File: design/rcem_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module rcem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/rcem_scan.sv
// Configuration registers and the raster position counters of the incoming pixel stream.
module rcem_scan (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [rcem_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rcem_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                             advance,
	output rcem_pkg::pos_t                   pos
);
	import rcem_pkg::*;

	logic [WCFG_W-1:0] width_q;
	logic [HCFG_W-1:0] height_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_max;
	logic [ROW_W-1:0]  row_max;

	// Out-of-range settings are clamped into [2, max] before use.
	always_comb begin
		if (width_q < WCFG_W'(2)) begin
			col_max = COL_W'(1);
		end else if (width_q > WCFG_W'(MAX_WIDTH)) begin
			col_max = COL_W'(MAX_WIDTH - 1);
		end else begin
			col_max = COL_W'(width_q - WCFG_W'(1));
		end
		if (height_q < HCFG_W'(2)) begin
			row_max = ROW_W'(1);
		end else if (height_q > HCFG_W'(MAX_HEIGHT)) begin
			row_max = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			row_max = ROW_W'(height_q - HCFG_W'(1));
		end
	end

	assign pos.col      = col_q;
	assign pos.row      = row_q;
	assign pos.last_col = (col_q >= col_max);
	assign pos.last_row = (row_q >= row_max);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WCFG_W'(630);
			height_q <= HCFG_W'(630);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			// A write to the width or height register restarts the frame.
			case (cfg_index)
				REG_WIDTH: begin
					width_q <= cfg_wdata[WCFG_W-1:0];
					col_q   <= '0;
					row_q   <= '0;
				end
				REG_HEIGHT: begin
					height_q <= cfg_wdata[HCFG_W-1:0];
					col_q    <= '0;
					row_q    <= '0;
				end
				default: begin
				end
			endcase
		end else if (advance) begin
			if (pos.last_col) begin
				col_q <= '0;
				row_q <= pos.last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

// File: design/rcem_kernel.sv
// 2x2 window registers and the four Roberts cross results that one pixel can produce.
module rcem_kernel (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic [rcem_pkg::PIX_W-1:0]        pixel,
	input  logic [rcem_pkg::PIX_W-1:0]        above,
	input  rcem_pkg::pos_t                    pos,
	output logic [rcem_pkg::NSLOT-1:0]        mask,
	output rcem_pkg::res_t [rcem_pkg::NSLOT-1:0] res
);
	import rcem_pkg::*;

	logic [PIX_W-1:0] left_q;
	logic [PIX_W-1:0] upper_left_q;
	logic             has_left;
	logic             has_above;

	assign has_left  = (pos.col != '0);
	assign has_above = (pos.row != '0);

	always_comb begin
		mask[SLOT_ABOVE]      = has_above && has_left;
		mask[SLOT_ABOVE_EDGE] = has_above && pos.last_col;
		mask[SLOT_BOTTOM]     = pos.last_row && has_left;
		mask[SLOT_CORNER]     = pos.last_row && pos.last_col;

		res[SLOT_ABOVE].mag = roberts(upper_left_q, above, left_q, pixel);
		res[SLOT_ABOVE].col = pos.col - COL_W'(1);
		res[SLOT_ABOVE].row = pos.row - ROW_W'(1);

		// Right neighbours are replicated from the edge column.
		res[SLOT_ABOVE_EDGE].mag = roberts(above, above, pixel, pixel);
		res[SLOT_ABOVE_EDGE].col = pos.col;
		res[SLOT_ABOVE_EDGE].row = pos.row - ROW_W'(1);

		// Bottom neighbours are replicated from the last row.
		res[SLOT_BOTTOM].mag = roberts(left_q, pixel, left_q, pixel);
		res[SLOT_BOTTOM].col = pos.col - COL_W'(1);
		res[SLOT_BOTTOM].row = pos.row;

		res[SLOT_CORNER].mag = '0;
		res[SLOT_CORNER].col = pos.col;
		res[SLOT_CORNER].row = pos.row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			upper_left_q <= '0;
		end else if (advance) begin
			left_q       <= pixel;
			upper_left_q <= above;
		end
	end

endmodule

// File: design/rcem_emit.sv
// Output register of a pixel's results, sent one per cycle while m_tready is high.
module rcem_emit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  logic [rcem_pkg::NSLOT-1:0]           mask_in,
	input  rcem_pkg::res_t [rcem_pkg::NSLOT-1:0] res_in,
	output logic                                 ready,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [rcem_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic                                 m_tlast,
	output logic                                 m_tuser
);
	import rcem_pkg::*;

	logic [NSLOT-1:0]            mask_q;
	res_t [NSLOT-1:0]            res_q;
	logic [SLOT_W-1:0]           sel;
	logic [NSLOT-1:0]            mask_rest;
	logic                        take;

	always_comb begin
		sel = SLOT_ABOVE;
		for (int i = NSLOT - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = SLOT_W'(i);
			end
		end
	end

	// Clearing the lowest set bit leaves what is still to be sent.
	assign mask_rest = mask_q & (mask_q - NSLOT'(1));
	assign take      = m_tvalid && m_tready;
	assign ready     = (mask_q == '0) || (take && (mask_rest == '0));

	assign m_tvalid = (mask_q != '0);
	assign m_tdata  = {{(M_TDATA_W - PIX_W - COL_W - ROW_W){1'b0}},
		res_q[sel].row, res_q[sel].col, res_q[sel].mag};
	assign m_tlast  = (mask_rest == '0);
	assign m_tuser  = (sel == SLOT_CORNER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= mask_in;
		end else if (take) begin
			mask_q <= mask_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// File: design/roberts_cross_edge_magnitude_unit.sv
// Roberts cross edge magnitude unit: 8-bit gray pixels enter in raster order, one per
// cycle while s_tready is high, and each yields zero to four results of |gx|+|gy|
// saturated at 255 with their column and row. The previous row sits in a 1024-entry line
// buffer RAM that is read and rewritten at the current column when a pixel is accepted;
// its data reaches the 2x2 window in the next cycle. The output sends one result per
// cycle while m_tready is high, so pixels with at most one result stream at one per
// cycle and a pixel with more than one holds the input until all but its last are sent
// (the right column below the first row and the bottom row past its first column give
// two, the bottom-right pixel four). A pixel is registered in s1 and its results in the
// output register. Pixels of the first row produce no result. The line buffer needs no
// clearing after reset. Writing either configuration register restarts the frame.
module roberts_cross_edge_magnitude_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rcem_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rcem_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [rcem_pkg::PIX_W-1:0]          s_tdata,   // [7:0] pixel
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rcem_pkg::M_TDATA_W-1:0]      m_tdata,   // [7:0] magnitude, [17:8] out_col,
	                                                       // [29:18] out_row, rest zero
	output logic                                m_tlast,   // run_last
	output logic                                m_tuser    // [0] frame_end
);
	import rcem_pkg::*;

	pos_t              pos;
	logic              accept;
	logic              s1_valid_q;
	logic              emit_ready;
	logic              s1_go;
	logic [PIX_W-1:0]  pixel_s1;
	pos_t              pos_s1;
	logic [PIX_W-1:0]  above;
	logic [NSLOT-1:0]  mask;
	res_t [NSLOT-1:0]  res;

	assign s1_go    = s1_valid_q && emit_ready;
	assign s_tready = !s1_valid_q || emit_ready;
	assign accept   = s_tvalid && s_tready;

	rcem_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.advance   (accept),
		.pos       (pos)
	);

	rcem_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_buf (
		.clk   (clk),
		.we    (accept),
		.waddr (pos.col),
		.wdata (s_tdata),
		.re    (accept),
		.raddr (pos.col),
		.rdata (above)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= s_tdata;
			pos_s1   <= pos;
		end
	end

	rcem_kernel u_kernel (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (s1_go),
		.pixel   (pixel_s1),
		.above   (above),
		.pos     (pos_s1),
		.mask    (mask),
		.res     (res)
	);

	rcem_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (s1_go),
		.mask_in  (mask),
		.res_in   (res),
		.ready    (emit_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// File: tb/rcem_checker.sv
// Checker for the Roberts cross edge magnitude unit: predicts every result and compares it.
module rcem_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rcem_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rcem_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [rcem_pkg::PIX_W-1:0]      s_tdata,   // [7:0] pixel
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [rcem_pkg::M_TDATA_W-1:0]  m_tdata,   // [7:0] magnitude, [17:8] out_col,
	                                                   // [29:18] out_row, rest zero
	input  logic                            m_tlast,   // run_last
	input  logic                            m_tuser,   // [0] frame_end
	output int                              fail_count,
	output int                              pending,
	output int                              results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	import rcem_pkg::*;

	localparam int DIM_AT_RESET = 630;
	localparam int ROW_LO = PIX_W + COL_W;
	localparam int PAD_LO = PIX_W + COL_W + ROW_W;

	typedef struct packed {
		logic [PIX_W-1:0] mag;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             frame_end;
		logic             run_last;
	} edge_result_t;

	logic [PIX_W-1:0]  prev_row [MAX_WIDTH];
	logic [COL_W-1:0]  col_pos;
	logic [ROW_W-1:0]  row_pos;
	logic [PIX_W-1:0]  left_px;
	logic [PIX_W-1:0]  upleft_px;
	logic [WCFG_W-1:0] width_reg;
	logic [HCFG_W-1:0] height_reg;
	edge_result_t      edge_q [$];
	int                err_total = 0;
	int                res_total = 0;

	function automatic int span_abs(int a, int b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic logic [PIX_W-1:0] cross_mag(int tl, int tr, int bl, int br);
		int m;
		m = span_abs(tl, br) + span_abs(tr, bl);
		return (m > int'(MAG_SAT)) ? MAG_SAT : PIX_W'(m);
	endfunction

	function automatic int field_diff(string label, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", label, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		int w, h, c, r, n;
		logic [PIX_W-1:0] px, up, ul, lf;
		logic at_right, at_bottom;
		edge_result_t res [NSLOT];
		edge_result_t want, got;
		if (!arst_n) begin
			for (int i = 0; i < MAX_WIDTH; i++) prev_row[i] = '0;
			col_pos = '0;
			row_pos = '0;
			left_px = '0;
			upleft_px = '0;
			width_reg = WCFG_W'(DIM_AT_RESET);
			height_reg = HCFG_W'(DIM_AT_RESET);
			edge_q.delete();
			pending <= 0;
		end else begin
			// A write to either known register also restarts the frame.
			if (cfg_we) begin
				if (cfg_index == REG_WIDTH) begin
					width_reg = cfg_wdata[WCFG_W-1:0];
					col_pos = '0;
					row_pos = '0;
				end else if (cfg_index == REG_HEIGHT) begin
					height_reg = cfg_wdata[HCFG_W-1:0];
					col_pos = '0;
					row_pos = '0;
				end
			end

			if (s_tvalid && s_tready) begin
				w = (width_reg < 2) ? 2 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
				h = (height_reg < 2) ? 2 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
				c = col_pos;
				r = row_pos;
				px = s_tdata;
				up = prev_row[c];
				ul = upleft_px;
				lf = left_px;
				at_right = (c >= w - 1);
				at_bottom = (r >= h - 1);
				n = 0;
				if (r >= 1) begin
					if (c >= 1) begin
						res[n] = '{cross_mag(ul, up, lf, px), COL_W'(c - 1), ROW_W'(r - 1),
							1'b0, 1'b0};
						n++;
					end
					// Right neighbours are replicated from the last column.
					if (at_right) begin
						res[n] = '{cross_mag(up, up, px, px), COL_W'(c), ROW_W'(r - 1),
							1'b0, 1'b0};
						n++;
					end
				end
				// The bottom row has no row below, so it replicates itself downward.
				if (at_bottom) begin
					if (c >= 1) begin
						res[n] = '{cross_mag(lf, px, lf, px), COL_W'(c - 1), ROW_W'(r),
							1'b0, 1'b0};
						n++;
					end
					if (at_right) begin
						res[n] = '{PIX_W'(0), COL_W'(c), ROW_W'(r), 1'b1, 1'b0};
						n++;
					end
				end
				if (n > 0) res[n - 1].run_last = 1'b1;
				for (int k = 0; k < n; k++) edge_q.push_back(res[k]);

				prev_row[c] = px;
				upleft_px = up;
				left_px = px;
				if (at_right) begin
					col_pos = '0;
					row_pos = at_bottom ? '0 : ROW_W'(r + 1);
				end else begin
					col_pos = COL_W'(c + 1);
				end
			end

			if (m_tvalid && m_tready) begin
				res_total++;
				got = '{m_tdata[PIX_W-1:0], m_tdata[PIX_W +: COL_W], m_tdata[ROW_LO +: ROW_W],
					m_tuser, m_tlast};
				if (edge_q.size() == 0) begin
					$error("result with no prediction pending: magnitude %0d, col %0d, row %0d",
						got.mag, got.col, got.row);
					err_total++;
				end else begin
					want = edge_q.pop_front();
					err_total += field_diff("magnitude", want.mag, got.mag);
					err_total += field_diff("out_col", want.col, got.col);
					err_total += field_diff("out_row", want.row, got.row);
					err_total += field_diff("frame_end", want.frame_end, got.frame_end);
					err_total += field_diff("run_last", want.run_last, got.run_last);
					err_total += field_diff("tdata padding", '0, m_tdata[M_TDATA_W-1:PAD_LO]);
				end
			end

			fail_count <= err_total;
			pending <= edge_q.size();
			results_seen <= res_total;
		end
	end

endmodule

// File: tb/tb_top.sv
// Top of the testbench: clock, reset, pixel and register stimulus, receiver stalls and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rcem_pkg::*;

	// Index outside the register map; the block must ignore it.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;

	localparam int DRAIN_CYCLES   = 16;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_ITEMS   = 430;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [PIX_W-1:0]      s_tdata;    // [7:0] pixel
	logic                  m_tvalid;
	logic                  m_tready;
	logic [M_TDATA_W-1:0]  m_tdata;    // [7:0] magnitude, [17:8] out_col, [29:18] out_row
	logic                  m_tlast;    // run_last
	logic                  m_tuser;    // [0] frame_end

	int fail_count;
	int pending;
	int results_seen;
	int pixels_sent = 0;
	int cfg_writes = 0;
	int idle_run = 0;
	bit calm = 1'b0;
	bit held_once = 1'b0;

	roberts_cross_edge_magnitude_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	rcem_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.m_tuser      (m_tuser),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return PIX_W'($urandom_range(0, 255));
	endfunction

	// Valid stays high from one request to the next unless a gap is drawn.
	task automatic push_pixel(input logic [PIX_W-1:0] px);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= px;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pixels_sent++;
	endtask

	task automatic send_run(input int count);
		for (int i = 0; i < count; i++) push_pixel(pick_pixel());
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cfg_writes++;
	endtask

	// Drains the block so that a register write finds it idle.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int w, h, ew, eh, sel, total, cut, done;
		bit spare_write;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First row of the reset-size frame: no results.
		push_pixel(8'hFF);
		push_pixel(8'h00);
		push_pixel(8'h80);
		settle();

		// Smallest frame: a saturating pattern, then one whose gradients cancel.
		write_reg(REG_WIDTH, 13'd2);
		write_reg(REG_HEIGHT, 13'd2);
		push_pixel(8'hFF);
		push_pixel(8'h00);
		push_pixel(8'hFF);
		push_pixel(8'h00);
		push_pixel(8'h00);
		push_pixel(8'hFF);
		push_pixel(8'hFF);
		push_pixel(8'h00);
		settle();

		// A write to an unmapped index in mid-frame must leave the position alone.
		write_reg(REG_WIDTH, 13'd3);
		write_reg(REG_HEIGHT, 13'd3);
		push_pixel(8'd10);
		push_pixel(8'd200);
		push_pixel(8'd30);
		push_pixel(8'd255);
		push_pixel(8'd0);
		settle();
		write_reg(REG_SPARE, 13'h1FFF);
		push_pixel(8'd90);
		push_pixel(8'd0);
		push_pixel(8'd255);
		push_pixel(8'd17);

		// A broken frame; the next register write restarts it.
		push_pixel(8'd1);
		push_pixel(8'd254);
		push_pixel(8'd127);
		push_pixel(8'd128);
		settle();

		done = 0;
		while (done < RANDOM_ITEMS) begin
			settle();
			calm = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 19);
			if (sel == 0) w = $urandom_range(0, 1);
			else if (sel < 4) w = $urandom_range(10, 40);
			else w = $urandom_range(2, 9);
			h = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
			ew = (w < 2) ? 2 : w;
			eh = (h < 2) ? 2 : h;
			// The width register is narrower than the write data; junk above it is dropped.
			if ($urandom_range(0, 1)) begin
				write_reg(REG_WIDTH, {2'($urandom_range(0, 3)), WCFG_W'(w)});
				write_reg(REG_HEIGHT, HCFG_W'(h));
			end else begin
				write_reg(REG_HEIGHT, HCFG_W'(h));
				write_reg(REG_WIDTH, {2'($urandom_range(0, 3)), WCFG_W'(w)});
			end
			total = ew * eh * $urandom_range(1, 3);
			if ($urandom_range(0, 3) == 0) total += $urandom_range(1, ew * eh - 1);
			if (total > RANDOM_ITEMS - done) total = RANDOM_ITEMS - done;
			spare_write = (total >= 2) && ($urandom_range(0, 5) == 0);
			cut = spare_write ? $urandom_range(1, total - 1) : total;
			send_run(cut);
			if (spare_write) begin
				settle();
				write_reg(REG_SPARE, CFG_DATA_W'($urandom));
				send_run(total - cut);
			end
			done += total;
		end

		settle();
		$display("Checked %0d results from %0d pixels across %0d register writes.",
			results_seen, pixels_sent, cfg_writes);
		$display("Frames ran from 2x2 up to 40 wide, with clamped sizes, restarts and stalls.");
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin : receiver
		int on_len, gap;
		m_tready = 1'b0;
		@(posedge clk);
		forever begin
			// One long hold-off while pixels keep coming, so the block backs up.
			if (!held_once && results_seen >= 200) begin
				held_once = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			on_len = $urandom_range(1, 24);
			m_tready <= 1'b1;
			repeat (on_len) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			idle_run <= 0;
		end else begin
			idle_run <= idle_run + 1;
		end
		if (idle_run >= WATCHDOG_LIMIT) begin
			$error("no request accepted for %0d cycles", WATCHDOG_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule

// File: filelist.f
design/rcem_pkg.sv
design/rcem_ram.sv
design/rcem_scan.sv
design/rcem_kernel.sv
design/rcem_emit.sv
design/roberts_cross_edge_magnitude_unit.sv
tb/rcem_checker.sv
tb/tb_top.sv
